FILE: rtl/core/bbso_pkg.sv
// Shared widths, codes and the stage enable struct of the box overlap test.
// Used by the datapath modules, the top level and the bench checker; depends on nothing.
package bbso_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned SIZE_BITS  = COORD_BITS - 1;
  // Doubled axis distance: a coordinate difference, doubled.
  localparam int unsigned DIST_BITS  = COORD_BITS + 2;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  localparam int unsigned ACC_BITS   = SQ_BITS + 2;
  localparam int unsigned NUM_AXES   = 3;

  typedef enum logic [1:0] {
    ACT_BOX     = 2'd0,
    ACT_SPHERE  = 2'd1,
    ACT_UNKNOWN = 2'd2
  } action_e;

  localparam logic [1:0] REG_BOX_SIZE_X = 2'd0;
  localparam logic [1:0] REG_BOX_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_BOX_SIZE_Z = 2'd2;

  // Load enables of the three datapath stages ahead of the output register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } bbso_en_t;

endpackage

FILE: rtl/core/bbso_axis.sv
// One axis of the overlap test: stages one and two (distance, box compare, sphere excess).
// Depends on bbso_pkg.
module bbso_axis (
  input  logic                                  clk_i,
  input  bbso_pkg::bbso_en_t                    en_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] box_center_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] other_center_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         box_size_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         other_size_i,
  input  logic [bbso_pkg::COORD_BITS-1:0]        r2_s1_i,
  output logic                                   box_ok_o,
  output logic                                   far_o,
  output logic [bbso_pkg::COORD_BITS-1:0]        dist_o
);

  logic signed [bbso_pkg::COORD_BITS:0] diff;
  logic [bbso_pkg::COORD_BITS:0]        mag;
  logic [bbso_pkg::DIST_BITS-1:0]       abs2_d, abs2_q;
  logic [bbso_pkg::COORD_BITS-1:0]      lim_d, lim_q;
  logic [bbso_pkg::SIZE_BITS-1:0]       bs_q;
  logic [bbso_pkg::DIST_BITS-1:0]       bs_ext;
  logic [bbso_pkg::DIST_BITS-1:0]       excess;
  logic                                 box_ok_d, box_ok_q;
  logic                                 far_d, far_q;
  logic [bbso_pkg::COORD_BITS-1:0]      dist_d, dist_q;

  // Stage one: doubled absolute center distance and the summed extents.
  always_comb begin
    diff   = $signed({other_center_i[bbso_pkg::COORD_BITS-1], other_center_i})
           - $signed({box_center_i[bbso_pkg::COORD_BITS-1], box_center_i});
    mag    = diff[bbso_pkg::COORD_BITS] ? (~diff + 1'b1) : diff;
    abs2_d = {mag, 1'b0};
    lim_d  = {1'b0, box_size_i} + {1'b0, other_size_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      abs2_q <= abs2_d;
      lim_q  <= lim_d;
      bs_q   <= box_size_i;
    end
  end

  // Stage two: box compare, far flag, and the doubled distance 2|t| - size outside the box span when positive.
  always_comb begin
    bs_ext   = {3'b000, bs_q};
    excess   = abs2_q - bs_ext;
    box_ok_d = abs2_q <= {2'b00, lim_q};
    far_d    = (abs2_q > bs_ext) && (excess >= {2'b00, r2_s1_i});
    dist_d   = (abs2_q > bs_ext) ? excess[bbso_pkg::COORD_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      box_ok_q <= box_ok_d;
      far_q    <= far_d;
      dist_q   <= dist_d;
    end
  end

  assign box_ok_o = box_ok_q;
  assign far_o    = far_q;
  assign dist_o   = dist_q;

endmodule

FILE: rtl/core/bbso_square.sv
// Stage three of the overlap test: squares of the per-axis excess and of the doubled radius.
// Depends on bbso_pkg.
module bbso_square (
  input  logic                                                    clk_i,
  input  bbso_pkg::bbso_en_t                                      en_i,
  input  logic [bbso_pkg::NUM_AXES-1:0][bbso_pkg::COORD_BITS-1:0] dist_i,
  input  logic [bbso_pkg::COORD_BITS-1:0]                         r2_i,
  output logic [bbso_pkg::NUM_AXES-1:0][bbso_pkg::SQ_BITS-1:0]    sq_o,
  output logic [bbso_pkg::SQ_BITS-1:0]                            rr_o
);

  logic [bbso_pkg::NUM_AXES-1:0][bbso_pkg::SQ_BITS-1:0] sq_d, sq_q;
  logic [bbso_pkg::SQ_BITS-1:0]                         rr_d, rr_q;

  always_comb begin
    for (int i = 0; i < int'(bbso_pkg::NUM_AXES); i++) begin
      sq_d[i] = bbso_pkg::SQ_BITS'(dist_i[i]) * bbso_pkg::SQ_BITS'(dist_i[i]);
    end
    rr_d = bbso_pkg::SQ_BITS'(r2_i) * bbso_pkg::SQ_BITS'(r2_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      sq_q <= sq_d;
      rr_q <= rr_d;
    end
  end

  assign sq_o = sq_q;
  assign rr_o = rr_q;

endmodule

FILE: rtl/core/box_box_sphere_overlap_test_unit.sv
// Channel  Valid        Ready        Payload
// input    in_valid_i   in_ready_o   action_i, box/other centers, other sizes, other_radius_i
// output   out_valid_o  out_ready_i  hit_o
// config   cfg_we_i     (none)       cfg_index_i, cfg_data_i
//
// Four register stages: distance, axis compare and excess, squares, then the sum
// compare into the output register. One transaction is taken every cycle unless a
// stalled output has filled the pipeline. Each stage loads when it is empty or the
// stage after it moves, so bubbles close up behind a stalled output. Reset empties
// the pipeline and sets every box extent to 1.0. Top level of the box overlap test;
// uses bbso_pkg, bbso_axis and bbso_square.
module box_box_sphere_overlap_test_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             action_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] box_center_x_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] box_center_y_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] box_center_z_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] other_center_x_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] other_center_y_i,
  input  logic signed [bbso_pkg::COORD_BITS-1:0] other_center_z_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         other_size_x_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         other_size_y_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         other_size_z_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         other_radius_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   hit_o,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_index_i,
  input  logic [bbso_pkg::SIZE_BITS-1:0]         cfg_data_i
);

  localparam int unsigned C = bbso_pkg::COORD_BITS;
  localparam int unsigned N = bbso_pkg::NUM_AXES;

  logic [bbso_pkg::SIZE_BITS-1:0] size_x_q, size_y_q, size_z_q;

  logic signed [N-1:0][C-1:0]            box_c, other_c;
  logic [N-1:0][bbso_pkg::SIZE_BITS-1:0] box_s, other_s;

  bbso_pkg::bbso_en_t en;
  logic               en_out;
  logic               v1_q, v2_q, v3_q, out_valid_q;

  logic [1:0]   act1_q, act2_q, act3_q;
  logic [C-1:0] r2_d, r2_1_q, r2_2_q;

  logic [N-1:0]        box_ok, far;
  logic [N-1:0][C-1:0] axis_dist;
  logic                box_all_q, far_any_q;

  logic [N-1:0][bbso_pkg::SQ_BITS-1:0] sq;
  logic [bbso_pkg::SQ_BITS-1:0]        rr;
  logic [bbso_pkg::ACC_BITS-1:0]       sq_sum;
  logic                                hit_d, hit_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= bbso_pkg::SIZE_BITS'(256);
      size_y_q <= bbso_pkg::SIZE_BITS'(256);
      size_z_q <= bbso_pkg::SIZE_BITS'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bbso_pkg::REG_BOX_SIZE_X: size_x_q <= cfg_data_i;
        bbso_pkg::REG_BOX_SIZE_Y: size_y_q <= cfg_data_i;
        bbso_pkg::REG_BOX_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall chain: a stage loads when it holds nothing or its successor loads.
  assign en_out     = !out_valid_q || out_ready_i;
  assign en.s3      = !v3_q || en_out;
  assign en.s2      = !v2_q || en.s3;
  assign en.s1      = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1) v1_q        <= in_valid_i;
      if (en.s2) v2_q        <= v1_q;
      if (en.s3) v3_q        <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  assign box_c   = {box_center_z_i, box_center_y_i, box_center_x_i};
  assign other_c = {other_center_z_i, other_center_y_i, other_center_x_i};
  assign box_s   = {size_z_q, size_y_q, size_x_q};
  assign other_s = {other_size_z_i, other_size_y_i, other_size_x_i};
  assign r2_d    = {other_radius_i, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      act1_q <= action_i;
      r2_1_q <= r2_d;
    end
    if (en.s2) begin
      act2_q <= act1_q;
      r2_2_q <= r2_1_q;
    end
    if (en.s3) begin
      act3_q    <= act2_q;
      box_all_q <= &box_ok;
      far_any_q <= |far;
    end
  end

  for (genvar a = 0; a < N; a++) begin : g_axis
    bbso_axis u_axis (
      .clk_i          (clk_i),
      .en_i           (en),
      .box_center_i   (box_c[a]),
      .other_center_i (other_c[a]),
      .box_size_i     (box_s[a]),
      .other_size_i   (other_s[a]),
      .r2_s1_i        (r2_1_q),
      .box_ok_o       (box_ok[a]),
      .far_o          (far[a]),
      .dist_o         (axis_dist[a])
    );
  end

  bbso_square u_square (
    .clk_i  (clk_i),
    .en_i   (en),
    .dist_i (axis_dist),
    .r2_i   (r2_2_q),
    .sq_o   (sq),
    .rr_o   (rr)
  );

  // The sphere hits when every excess is below the doubled radius and the
  // squared excesses sum to strictly less than the squared doubled radius.
  always_comb begin
    sq_sum = bbso_pkg::ACC_BITS'(sq[0]) + bbso_pkg::ACC_BITS'(sq[1])
           + bbso_pkg::ACC_BITS'(sq[2]);
    case (act3_q)
      bbso_pkg::ACT_BOX:    hit_d = box_all_q;
      bbso_pkg::ACT_SPHERE: hit_d = !far_any_q && (sq_sum < bbso_pkg::ACC_BITS'(rr));
      default:              hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

FILE: rtl/core/bbso_checker.sv
// Port-level checks for the box overlap test, bound to its top level.
// Depends only on the top level's port names.
module bbso_port_checks (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic hit_o
);

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Transactions taken in and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o))
    else $error("result changed while stalled");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while the output side can move");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result shown with no transaction outstanding");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

endmodule

bind box_box_sphere_overlap_test_unit bbso_port_checks u_bbso_port_checks (.*);

FILE: verif/bbso_checker.sv
// Checker for the box overlap test unit: watches both channels and the register port,
// predicts the hit flag of every accepted transaction and compares it in order.
// Depends on bbso_pkg for widths, action codes and register indexes.
module bbso_checker
  import bbso_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    action_i,
  input  logic signed [COORD_BITS-1:0]  box_center_x_i,
  input  logic signed [COORD_BITS-1:0]  box_center_y_i,
  input  logic signed [COORD_BITS-1:0]  box_center_z_i,
  input  logic signed [COORD_BITS-1:0]  other_center_x_i,
  input  logic signed [COORD_BITS-1:0]  other_center_y_i,
  input  logic signed [COORD_BITS-1:0]  other_center_z_i,
  input  logic [SIZE_BITS-1:0]          other_size_x_i,
  input  logic [SIZE_BITS-1:0]          other_size_y_i,
  input  logic [SIZE_BITS-1:0]          other_size_z_i,
  input  logic [SIZE_BITS-1:0]          other_radius_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          hit_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [SIZE_BITS-1:0]          cfg_data_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);

  typedef struct {
    bit          hit;
    int unsigned serial;
  } hit_entry_t;

  logic [SIZE_BITS-1:0] box_size_x, box_size_y, box_size_z;
  hit_entry_t           hit_expected [$];
  int unsigned          in_serial;

  initial mismatches_o = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  function automatic bit box_axis_overlaps(longint bc, longint oc, longint bs, longint os);
    longint d;
    d = bc - oc;
    if (d < 0) d = -d;
    return (2 * d) <= (bs + os);
  endfunction

  // Doubled distance of the sphere center outside the box span on one axis.
  function automatic longint sphere_axis_gap(longint bc, longint oc, longint bs);
    longint p, lo, hi;
    p  = 2 * oc;
    lo = 2 * bc - bs;
    hi = 2 * bc + bs;
    if (p < lo) return lo - p;
    if (p > hi) return p - hi;
    return 0;
  endfunction

  function automatic bit predict_hit(
    logic [1:0] kind,
    longint bcx, longint bcy, longint bcz,
    longint ocx, longint ocy, longint ocz,
    longint osx, longint osy, longint osz,
    longint radius
  );
    longint gx, gy, gz, r2;
    case (kind)
      ACT_BOX: begin
        return box_axis_overlaps(bcx, ocx, longint'(box_size_x), osx) &&
               box_axis_overlaps(bcy, ocy, longint'(box_size_y), osy) &&
               box_axis_overlaps(bcz, ocz, longint'(box_size_z), osz);
      end
      ACT_SPHERE: begin
        // Every gap stays below 2^27, so the exact sum of squares fits easily.
        gx = sphere_axis_gap(bcx, ocx, longint'(box_size_x));
        gy = sphere_axis_gap(bcy, ocy, longint'(box_size_y));
        gz = sphere_axis_gap(bcz, ocz, longint'(box_size_z));
        r2 = 2 * radius;
        return (r2 * r2 - (gx * gx + gy * gy + gz * gz)) > 0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_entry_t entry;
    if (!rst_ni) begin
      box_size_x = SIZE_BITS'(256);
      box_size_y = SIZE_BITS'(256);
      box_size_z = SIZE_BITS'(256);
      hit_expected.delete();
      in_serial  = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (hit_expected.size() == 0) begin
          report_mismatch($sformatf("result hit=%0b with no transaction outstanding", hit_i));
        end else begin
          entry = hit_expected.pop_front();
          if (hit_i !== entry.hit) begin
            report_mismatch($sformatf("transaction %0d: hit=%0b, predicted %0b",
                                      entry.serial, hit_i, entry.hit));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        entry.serial = in_serial;
        entry.hit = predict_hit(action_i,
                                box_center_x_i, box_center_y_i, box_center_z_i,
                                other_center_x_i, other_center_y_i, other_center_z_i,
                                other_size_x_i, other_size_y_i, other_size_z_i,
                                other_radius_i);
        hit_expected.push_back(entry);
        in_serial++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BOX_SIZE_X: box_size_x = cfg_data_i;
          REG_BOX_SIZE_Y: box_size_y = cfg_data_i;
          REG_BOX_SIZE_Z: box_size_z = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = hit_expected.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Top of the box overlap test bench: clock, reset, stimulus and receiver stalls, with
// the DUT and bbso_checker side by side. Depends on bbso_pkg, the RTL and the checker.
module tb_top;
  import bbso_pkg::*;

  localparam int CMAX        = 2 ** (COORD_BITS - 1) - 1;
  localparam int CMIN        = -(2 ** (COORD_BITS - 1));
  localparam int SMAX        = 2 ** SIZE_BITS - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 275;

  typedef struct {
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] bc_x, bc_y, bc_z;
    logic signed [COORD_BITS-1:0] oc_x, oc_y, oc_z;
    logic [SIZE_BITS-1:0]         os_x, os_y, os_z;
    logic [SIZE_BITS-1:0]         radius;
  } pair_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid, in_ready;
  logic [1:0]                   action;
  logic signed [COORD_BITS-1:0] box_center_x, box_center_y, box_center_z;
  logic signed [COORD_BITS-1:0] other_center_x, other_center_y, other_center_z;
  logic [SIZE_BITS-1:0]         other_size_x, other_size_y, other_size_z, other_radius;
  logic                         out_valid, out_ready, hit;
  logic                         cfg_we;
  logic [1:0]                   cfg_index;
  logic [SIZE_BITS-1:0]         cfg_data;
  int unsigned                  mismatches, pending;
  bit                           hold_req, hold_done;
  int                           cur_size [3];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  box_box_sphere_overlap_test_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .box_center_x_i   (box_center_x),
    .box_center_y_i   (box_center_y),
    .box_center_z_i   (box_center_z),
    .other_center_x_i (other_center_x),
    .other_center_y_i (other_center_y),
    .other_center_z_i (other_center_z),
    .other_size_x_i   (other_size_x),
    .other_size_y_i   (other_size_y),
    .other_size_z_i   (other_size_z),
    .other_radius_i   (other_radius),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .hit_o            (hit),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  bbso_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .box_center_x_i   (box_center_x),
    .box_center_y_i   (box_center_y),
    .box_center_z_i   (box_center_z),
    .other_center_x_i (other_center_x),
    .other_center_y_i (other_center_y),
    .other_center_z_i (other_center_z),
    .other_size_x_i   (other_size_x),
    .other_size_y_i   (other_size_y),
    .other_size_z_i   (other_size_z),
    .other_radius_i   (other_radius),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .hit_i            (hit),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2, 3, 4: return $urandom_range(1, 1023);
      5, 6, 7: return $urandom_range(1024, 65535);
      8:       return $urandom_range(65536, SMAX);
      default: return SMAX;
    endcase
  endfunction

  function automatic pair_t mk(logic [1:0] act, int bx, int by, int bz, int ox, int oy,
                               int oz, int sx, int sy, int sz, int rad);
    pair_t p;
    p.action = act;
    p.bc_x = COORD_BITS'(bx); p.bc_y = COORD_BITS'(by); p.bc_z = COORD_BITS'(bz);
    p.oc_x = COORD_BITS'(ox); p.oc_y = COORD_BITS'(oy); p.oc_z = COORD_BITS'(oz);
    p.os_x = SIZE_BITS'(sx); p.os_y = SIZE_BITS'(sy); p.os_z = SIZE_BITS'(sz);
    p.radius = SIZE_BITS'(rad);
    return p;
  endfunction

  // Other center placed around the box center so that the axis lands on either side of
  // the touching distance, sometimes exactly on it.
  function automatic logic [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] base,
                                                       longint span);
    longint half, off;
    logic [COORD_BITS-1:0] c;
    half = span / 2;
    case ($urandom_range(0, 9))
      0:       off = half;
      1:       off = half + 1;
      default: off = $urandom_range(0, 32'(half + half / 4 + 1));
    endcase
    if ($urandom_range(0, 1)) off = -off;
    c = COORD_BITS'(longint'(base) + off);
    return c;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    r;
    p.bc_x = COORD_BITS'($urandom); p.bc_y = COORD_BITS'($urandom);
    p.bc_z = COORD_BITS'($urandom);
    p.oc_x = COORD_BITS'($urandom); p.oc_y = COORD_BITS'($urandom);
    p.oc_z = COORD_BITS'($urandom);
    p.os_x = SIZE_BITS'($urandom); p.os_y = SIZE_BITS'($urandom);
    p.os_z = SIZE_BITS'($urandom);
    p.radius = SIZE_BITS'($urandom);
    p.action = 2'($urandom);
    if ($urandom_range(0, 4) == 0) return p;
    r = $urandom_range(0, 99);
    if (r < 45) p.action = ACT_BOX;
    else if (r < 90) p.action = ACT_SPHERE;
    else p.action = 2'($urandom_range(ACT_UNKNOWN, 3));
    p.os_x = SIZE_BITS'(rand_len()); p.os_y = SIZE_BITS'(rand_len());
    p.os_z = SIZE_BITS'(rand_len());
    p.radius = SIZE_BITS'(rand_len());
    if (p.action == ACT_SPHERE) begin
      p.oc_x = near_coord(p.bc_x, longint'(cur_size[0]) + 2 * longint'(p.radius));
      p.oc_y = near_coord(p.bc_y, longint'(cur_size[1]) + 2 * longint'(p.radius));
      p.oc_z = near_coord(p.bc_z, longint'(cur_size[2]) + 2 * longint'(p.radius));
    end else begin
      p.oc_x = near_coord(p.bc_x, longint'(cur_size[0]) + longint'(p.os_x));
      p.oc_y = near_coord(p.bc_y, longint'(cur_size[1]) + longint'(p.os_y));
      p.oc_z = near_coord(p.bc_z, longint'(cur_size[2]) + longint'(p.os_z));
    end
    return p;
  endfunction

  task automatic drive_pair(pair_t p, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action         = p.action;
    box_center_x   = p.bc_x;
    box_center_y   = p.bc_y;
    box_center_z   = p.bc_z;
    other_center_x = p.oc_x;
    other_center_y = p.oc_y;
    other_center_z = p.oc_z;
    other_size_x   = p.os_x;
    other_size_y   = p.os_y;
    other_size_z   = p.os_z;
    other_radius   = p.radius;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every outstanding transaction has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = SIZE_BITS'(data);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_box_size(int sx, int sy, int sz);
    write_reg(REG_BOX_SIZE_X, sx);
    write_reg(REG_BOX_SIZE_Y, sy);
    write_reg(REG_BOX_SIZE_Z, sz);
    cur_size[0] = sx;
    cur_size[1] = sy;
    cur_size[2] = sz;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int stall_left, calm_left;
    out_ready  = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm_left > 0) begin
        out_ready = 1'b1;
        calm_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 200);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Ends the run when no transaction has moved on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int calm_items;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    action         = '0;
    box_center_x   = '0;
    box_center_y   = '0;
    box_center_z   = '0;
    other_center_x = '0;
    other_center_y = '0;
    other_center_z = '0;
    other_size_x   = '0;
    other_size_y   = '0;
    other_size_z   = '0;
    other_radius   = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    cur_size       = '{256, 256, 256};
    calm_items     = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed cases with the reset box size of 1.0 (half extent 128).
    drive_pair(mk(ACT_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    drive_pair(mk(ACT_BOX, 0, 0, 0, 256, 0, 0, 256, 256, 256, 0), 0);
    drive_pair(mk(ACT_BOX, 0, 0, 0, 257, 0, 0, 256, 256, 256, 0), 1);
    drive_pair(mk(ACT_BOX, 0, 0, 0, 0, -257, 0, 256, 256, 256, 0), 0);
    drive_pair(mk(ACT_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX, 0), 0);
    drive_pair(mk(ACT_BOX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, SMAX, SMAX, SMAX, SMAX), 2);
    drive_pair(mk(ACT_BOX, 0, 0, 0, 300, 0, 0, 0, 0, 0, SMAX), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0);
    // A sphere exactly touching a face stays a miss; one step larger is a hit.
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 228, 0, 0, 0, 0, 0, 100), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 228, 0, 0, 0, 0, 0, 101), 3);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 228, 228, 228, 0, 0, 0, 100), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 228, 228, 228, 0, 0, 0, 173), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 228, 228, 228, 0, 0, 0, 180), 0);
    drive_pair(mk(ACT_SPHERE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, SMAX), 0);
    drive_pair(mk(ACT_SPHERE, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, 0, 0, 0, SMAX), 0);
    drive_pair(mk(ACT_SPHERE, 0, 0, 0, 300, 0, 0, SMAX, SMAX, SMAX, 10), 0);
    drive_pair(mk(ACT_UNKNOWN, 0, 0, 0, 0, 0, 0, SMAX, SMAX, SMAX, SMAX), 0);
    drive_pair(mk(2'd3, 0, 0, 0, 0, 0, 0, SMAX, SMAX, SMAX, SMAX), 0);
    drain();

    set_box_size(0, 0, 0);
    drive_pair(mk(ACT_BOX, 5, 5, 5, 5, 5, 5, 0, 0, 0, 0), 0);
    drive_pair(mk(ACT_BOX, 5, 5, 5, 6, 5, 5, 0, 0, 0, 0), 0);
    drive_pair(mk(ACT_SPHERE, 5, 5, 5, 5, 5, 5, 0, 0, 0, 1), 0);
    drain();

    set_box_size(SMAX, SMAX, SMAX);
    drive_pair(mk(ACT_BOX, -(2 ** 22), 0, 0, 2 ** 22, 0, 0, SMAX, 0, 0, 0), 0);
    drive_pair(mk(ACT_BOX, -(2 ** 22), 0, 0, 2 ** 22 - 1, 0, 0, SMAX, 0, 0, 0), 0);
    drive_pair(mk(ACT_SPHERE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, SMAX), 0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_box_size(rand_len(), rand_len(), rand_len());
        1: begin
          set_box_size(SMAX, SMAX, SMAX);
          // Index 3 names no register and must leave the sizes alone.
          write_reg(2'd3, 1234);
        end
        2: set_box_size(0, 0, 0);
        3: set_box_size(0, SMAX, $urandom_range(1, 4095));
        4: set_box_size(256, 256, 256);
        default: set_box_size(rand_len(), rand_len(), rand_len());
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
        if (calm_items > 0) calm_items--;
        else if ($urandom_range(0, 39) == 0) calm_items = $urandom_range(20, 60);
        drive_pair(random_pair(), (calm_items > 0) ? 0 : pick_gap());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
